// ===== rtl/core/overlap_rebin_accumulator_macros.svh =====
// Assertion macros for the overlap rebin accumulator.
`ifndef OVERLAP_REBIN_ACCUMULATOR_MACROS_SVH
`define OVERLAP_REBIN_ACCUMULATOR_MACROS_SVH
`ifndef SYNTH
`define ORA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ORA_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ORA_ASSERT(label, clk, rst_n, prop, msg)
`define ORA_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== rtl/core/ora_pkg.sv =====
`timescale 1ns / 1ps
package ora_pkg;
    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_LOAD    = 2'd1;
    localparam logic [1:0] OP_TARGET  = 2'd2;
    localparam int unsigned AMOUNT_W  = 40;
    localparam logic [AMOUNT_W-1:0] AMOUNT_MAX = {AMOUNT_W{1'b1}};
    localparam logic [8:0] TCOUNT_MAX = 9'd511;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_DIV,
        ST_ADD,
        ST_OUT
    } state_t;

    // Divider request and answer
    typedef struct packed {
        logic        start;
        logic [47:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [47:0] quotient;
    } div_rsp_t;
endpackage

// ===== rtl/core/ora_divider.sv =====
`timescale 1ns / 1ps
module ora_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  ora_pkg::div_req_t req,
    output ora_pkg::div_rsp_t rsp
);
    logic [47:0] quot_reg, quot_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;

    // One quotient bit per cycle, restoring
    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[15:0], quot_reg[47]};
        if (req.start)
        begin
            quot_next = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next  = trial - {1'b0, dvs_reg};
                quot_next = {quot_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;
endmodule

// ===== rtl/core/ora_source_table.sv =====
`timescale 1ns / 1ps
module ora_source_table
#(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [63:0]   wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [63:0]   rd_data
);
    // lower, upper and production packed into one word
    logic [63:0] mem [DEPTH];
    logic [63:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== rtl/core/overlap_rebin_accumulator.sv =====
`timescale 1ns / 1ps
// Source bins load into a table; a target bin walks the source bins it
// touches (every bin it passes plus the one that straddles its upper edge);
// each nonzero share goes through a 48-step bit-serial divider after a table
// read, and a bin that contributes nothing skips the divider. A clear, a load
// and the first target of a pass are handled without a table walk. Results
// wait in an output register, and a new item is accepted once the previous
// result has been taken.
`include "overlap_rebin_accumulator_macros.svh"
module overlap_rebin_accumulator
#(
    parameter int unsigned MAX_SOURCE_BINS = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [15:0] bin_lower,
    input  logic [15:0] bin_upper,
    input  logic [31:0] bin_amount,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [39:0] target_amount,
    output logic        amount_valid,
    output logic        saturated
);
    localparam int unsigned AW = (MAX_SOURCE_BINS > 1) ? $clog2(MAX_SOURCE_BINS) : 1;
    localparam int unsigned CW = $clog2(MAX_SOURCE_BINS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SOURCE_BINS);

    ora_pkg::state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [8:0]    tcnt_reg, tcnt_next;
    logic [15:0]   lo_reg, lo_next, up_reg, up_next;
    logic [39:0]   acc_reg, acc_next;
    logic          sat_reg, sat_next;
    logic          last_reg, last_next;
    logic [15:0]   wid_reg, wid_next;
    logic [47:0]   prod_reg, prod_next;
    logic          zero_reg, zero_next;
    logic          ovalid_reg, ovalid_next;
    logic [39:0]   oamt_reg, oamt_next;
    logic          oav_reg, oav_next, osat_reg, osat_next;

    logic          wr_en;
    logic [AW-1:0] rd_addr;
    logic [63:0]   rd_data;
    logic [15:0]   s_lo, s_hi, start, top;
    logic [31:0]   s_prod;
    logic [40:0]   sum;
    ora_pkg::div_req_t dreq;
    ora_pkg::div_rsp_t drsp;

    assign wr_en   = in_valid && in_ready && (opcode == ora_pkg::OP_LOAD)
                     && (cnt_reg < CNT_MAX);
    assign rd_addr = ptr_reg[AW-1:0];

    ora_source_table #(.DEPTH(MAX_SOURCE_BINS), .AW(AW)) u_table
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[AW-1:0]),
        .wr_data ({bin_lower, bin_upper, bin_amount}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ora_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign s_lo   = rd_data[63:48];
    assign s_hi   = rd_data[47:32];
    assign s_prod = rd_data[31:0];
    assign start  = (s_lo > lo_reg) ? s_lo : lo_reg;
    assign top    = (up_reg < s_hi) ? up_reg : s_hi;
    assign sum    = {1'b0, acc_reg} + {1'b0, drsp.quotient[39:0]}
                    + {40'd0, |drsp.quotient[47:40]};

    assign in_ready = (state_reg == ora_pkg::ST_IDLE) && !ovalid_reg;

    // Sequence one item: a clear, a load, or a target through read, evaluate, divide, accumulate, output
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ptr_next    = ptr_reg;
        tcnt_next   = tcnt_reg;
        lo_next     = lo_reg;
        up_next     = up_reg;
        acc_next    = acc_reg;
        sat_next    = sat_reg;
        last_next   = last_reg;
        wid_next    = wid_reg;
        prod_next   = prod_reg;
        zero_next   = zero_reg;
        ovalid_next = ovalid_reg;
        oamt_next   = oamt_reg;
        oav_next    = oav_reg;
        osat_next   = osat_reg;
        dreq.start    = 1'b0;
        dreq.dividend = prod_reg;
        dreq.divisor  = wid_reg;
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end
        case (state_reg)
            ora_pkg::ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    case (opcode)
                        ora_pkg::OP_CLEAR:
                        begin
                            cnt_next  = '0;
                            ptr_next  = CW'(1);
                            tcnt_next = '0;
                        end
                        ora_pkg::OP_LOAD:
                        begin
                            if (cnt_reg < CNT_MAX)
                            begin
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        ora_pkg::OP_TARGET:
                        begin
                            if (tcnt_reg == 9'd0)
                            begin
                                tcnt_next   = 9'd1;
                                ovalid_next = 1'b1;
                                oamt_next   = '0;
                                oav_next    = 1'b0;
                                osat_next   = 1'b0;
                            end
                            else
                            begin
                                if (tcnt_reg < ora_pkg::TCOUNT_MAX)
                                begin
                                    tcnt_next = tcnt_reg + 9'd1;
                                end
                                lo_next    = bin_lower;
                                up_next    = bin_upper;
                                acc_next   = '0;
                                sat_next   = 1'b0;
                                state_next = ora_pkg::ST_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ora_pkg::ST_READ:
            begin
                // table out of entries: finish
                if (ptr_reg >= cnt_reg)
                begin
                    state_next = ora_pkg::ST_OUT;
                end
                else
                begin
                    state_next = ora_pkg::ST_EVAL;
                end
            end
            ora_pkg::ST_EVAL:
            begin
                last_next = (up_reg < s_hi);
                wid_next  = s_hi - s_lo;
                prod_next = s_prod * (top - start);
                zero_next = (s_hi <= s_lo) || (top <= start);
                if ((s_hi <= s_lo) || (top <= start))
                begin
                    state_next = ora_pkg::ST_ADD;
                end
                else
                begin
                    state_next = ora_pkg::ST_DIV;
                end
            end
            ora_pkg::ST_DIV:
            begin
                dreq.start = 1'b1;
                state_next = ora_pkg::ST_ADD;
            end
            ora_pkg::ST_ADD:
            begin
                if (zero_reg || drsp.done)
                begin
                    if (!zero_reg)
                    begin
                        if (sum > {1'b0, ora_pkg::AMOUNT_MAX})
                        begin
                            acc_next = ora_pkg::AMOUNT_MAX;
                            sat_next = 1'b1;
                        end
                        else
                        begin
                            acc_next = sum[39:0];
                        end
                    end
                    if (last_reg)
                    begin
                        state_next = ora_pkg::ST_OUT;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + CW'(1);
                        state_next = ora_pkg::ST_READ;
                    end
                end
            end
            ora_pkg::ST_OUT:
            begin
                if (!ovalid_reg)
                begin
                    ovalid_next = 1'b1;
                    oamt_next   = acc_reg;
                    oav_next    = 1'b1;
                    osat_next   = sat_reg;
                    state_next  = ora_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ora_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ora_pkg::ST_IDLE;
            cnt_reg    <= '0;
            ptr_reg    <= CW'(1);
            tcnt_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ptr_reg    <= ptr_next;
            tcnt_reg   <= tcnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_next;
        up_reg   <= up_next;
        acc_reg  <= acc_next;
        sat_reg  <= sat_next;
        last_reg <= last_next;
        wid_reg  <= wid_next;
        prod_reg <= prod_next;
        zero_reg <= zero_next;
        oamt_reg <= oamt_next;
        oav_reg  <= oav_next;
        osat_reg <= osat_next;
    end

    assign out_valid     = ovalid_reg;
    assign target_amount = oamt_reg;
    assign amount_valid  = oav_reg;
    assign saturated     = osat_reg;

    `ORA_ASSERT(a_ptr_bound, clk, rst_n, ptr_reg <= CNT_MAX, "pointer past table")
    `ORA_ASSERT(a_cnt_bound, clk, rst_n, cnt_reg <= CNT_MAX, "count past table")
    `ORA_ASSERT(a_busy_stall, clk, rst_n, (state_reg != ora_pkg::ST_IDLE) |-> !in_ready, "busy")
    `ORA_ASSERT(a_inv_zero, clk, rst_n, out_valid && !amount_valid |-> target_amount == '0, "nonzero")
endmodule

// ===== sim/overlap_rebin_accumulator_tb.sv =====
`timescale 1ns / 1ps
module overlap_rebin_accumulator_tb;

    localparam int unsigned SRC_DEPTH   = 256;
    localparam int unsigned CYCLE_LIMIT = 1500000;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;

    typedef struct packed {
        logic [39:0] amount;
        logic        valid;
        logic        sat;
    } target_res_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] lo;
        logic [15:0] up;
        logic [31:0] amt;
        logic        typed;
        target_res_t res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [15:0] bin_lower;
    logic [15:0] bin_upper;
    logic [31:0] bin_amount;
    logic        out_valid;
    logic        out_ready;
    logic [39:0] target_amount;
    logic        amount_valid;
    logic        saturated;

    // Shadow copy of the source table and pointers
    logic [15:0] tbl_lower [SRC_DEPTH];
    logic [15:0] tbl_upper [SRC_DEPTH];
    logic [31:0] tbl_prod  [SRC_DEPTH];
    int unsigned tbl_count;
    int unsigned walk_ptr;
    int unsigned targets_seen;

    target_res_t expected_targets[$];
    int          errors;
    int          items_sent;
    int          targets_checked;
    int          full_tables;
    int          idle_mode;
    bit          hold_req;
    int          hold_cnt;
    longint      cycles;

    overlap_rebin_accumulator dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .opcode(opcode),
        .bin_lower(bin_lower),
        .bin_upper(bin_upper),
        .bin_amount(bin_amount),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .target_amount(target_amount),
        .amount_valid(amount_valid),
        .saturated(saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Share of entry k over [from, to): floor(prod * overlap / width)
    function automatic logic [63:0] bin_share(int unsigned k, int unsigned from,
                                              int unsigned to);
        int unsigned start;
        logic [63:0] width;
        logic [63:0] overlap;
        start = (tbl_lower[k] > from) ? tbl_lower[k] : from;
        if (tbl_upper[k] <= tbl_lower[k]) return 64'd0;
        if (to <= start) return 64'd0;
        width   = 64'(tbl_upper[k] - tbl_lower[k]);
        overlap = 64'(to - start);
        return (64'(tbl_prod[k]) * overlap) / width;
    endfunction

    // Update shadow state; return 1 with the target amount when a result is due
    function automatic bit rebin_predict(logic [1:0] op, logic [15:0] lo,
                                         logic [15:0] up, logic [31:0] amt,
                                         output target_res_t res);
        logic [63:0] acc;
        int unsigned j;
        acc = 64'd0;
        res = '0;
        if (op == ora_pkg::OP_CLEAR) begin
            tbl_count = 0;
            walk_ptr = 1;
            targets_seen = 0;
            return 1'b0;
        end
        if (op == ora_pkg::OP_LOAD) begin
            if (tbl_count < SRC_DEPTH) begin
                tbl_lower[tbl_count] = lo;
                tbl_upper[tbl_count] = up;
                tbl_prod[tbl_count]  = amt;
                tbl_count++;
            end
            return 1'b0;
        end
        if (op != ora_pkg::OP_TARGET) return 1'b0;
        if (targets_seen == 0) begin
            targets_seen = 1;
            return 1'b1;
        end
        if (targets_seen < ora_pkg::TCOUNT_MAX) targets_seen++;
        j = walk_ptr;
        while (j < tbl_count && up >= tbl_upper[j]) begin
            acc = acc + bin_share(j, lo, tbl_upper[j]);
            if (acc > 64'(ora_pkg::AMOUNT_MAX)) begin
                acc = 64'(ora_pkg::AMOUNT_MAX);
                res.sat = 1'b1;
            end
            j++;
        end
        if (j < tbl_count) begin
            acc = acc + bin_share(j, lo, up);
            if (acc > 64'(ora_pkg::AMOUNT_MAX)) begin
                acc = 64'(ora_pkg::AMOUNT_MAX);
                res.sat = 1'b1;
            end
        end
        walk_ptr = j;
        res.amount = acc[39:0];
        res.valid = 1'b1;
        return 1'b1;
    endfunction

    // Offer one item, hold it until accepted, then predict
    task automatic send_item(logic [1:0] op, logic [15:0] lo, logic [15:0] up,
                             logic [31:0] amt, bit typed = 0,
                             target_res_t typed_res = '0);
        int unsigned pct;
        target_res_t res;
        pct = (idle_mode == 1) ? 52 : (idle_mode == 3) ? 30 : 0;
        while ($urandom_range(99) < pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        opcode = op;
        bin_lower = lo;
        bin_upper = up;
        bin_amount = amt;
        in_valid = 1'b1;
        do @(posedge clk); while (!(in_valid && in_ready));
        if (rebin_predict(op, lo, up, amt, res))
            expected_targets.insert(expected_targets.size(), typed ? typed_res : res);
        if (op != OP_UNUSED) items_sent++;
        @(negedge clk);
    endtask

    // Pass: a clear, mostly contiguous sources, then mostly ascending targets
    task automatic run_pass(int unsigned n_src, int unsigned n_tgt);
        int unsigned edge_lo;
        int unsigned edge_hi;
        int unsigned step;
        int unsigned span;
        int unsigned k;
        send_item(ora_pkg::OP_CLEAR, 16'($urandom), 16'($urandom), $urandom);
        step = (n_src > 40) ? 200 : 3000;
        edge_lo = $urandom_range(0, 4000);
        for (k = 0; k < n_src; k++) begin
            edge_hi = edge_lo + $urandom_range(0, step);
            if (edge_hi > 65535) edge_hi = 65535;
            // occasionally break contiguity or invert a bin
            if ($urandom_range(15) == 0)
                send_item(ora_pkg::OP_LOAD, 16'(edge_hi), 16'(edge_lo), $urandom);
            else
                send_item(ora_pkg::OP_LOAD, 16'(edge_lo), 16'(edge_hi),
                          ($urandom_range(7) == 0) ? 32'hFFFF_FFFF : $urandom);
            edge_lo = edge_hi;
        end
        span = edge_lo + 2000;
        edge_lo = $urandom_range(0, 3000);
        send_item(ora_pkg::OP_TARGET, 16'(edge_lo), 16'(edge_lo), $urandom);
        for (k = 0; k < n_tgt; k++) begin
            edge_hi = edge_lo + $urandom_range(0, 2 * span / (n_tgt + 1) + 1);
            if (edge_hi > 65535) edge_hi = 65535;
            if ($urandom_range(9) == 0)
                send_item(ora_pkg::OP_TARGET, 16'($urandom), 16'($urandom), $urandom);
            else
                send_item(ora_pkg::OP_TARGET, 16'(edge_lo), 16'(edge_hi), $urandom);
            edge_lo = edge_hi;
        end
    endtask

    // Receiver: always ready, random stalls, or a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req && hold_cnt == 0) begin
            hold_cnt <= 400;
            hold_req <= 1'b0;
            out_ready <= 1'b0;
        end
        else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            out_ready <= 1'b0;
        end
        else if (idle_mode == 2)
            out_ready <= ($urandom_range(99) >= 52);
        else if (idle_mode == 3)
            out_ready <= ($urandom_range(99) >= 30);
        else
            out_ready <= 1'b1;
    end

    // Compare each result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_targets.size() == 0) begin
                $error("result with no expectation: amount %h", target_amount);
                errors++;
            end
            else begin
                target_res_t e;
                e = expected_targets.pop_front();
                if (target_amount !== e.amount) begin
                    $error("target_amount exp %h got %h", e.amount, target_amount);
                    errors++;
                end
                if (amount_valid !== e.valid) begin
                    $error("amount_valid exp %b got %b", e.valid, amount_valid);
                    errors++;
                end
                if (saturated !== e.sat) begin
                    $error("saturated exp %b got %b", e.sat, saturated);
                    errors++;
                end
                targets_checked++;
            end
        end
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    stim_row_t directed[20] = '{
        '{ora_pkg::OP_TARGET, 16'h0000, 16'h0100, 32'h0,   1'b1, '{40'h0, 1'b0, 1'b0}},
        '{ora_pkg::OP_CLEAR,  16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, '0},
        '{ora_pkg::OP_LOAD,   16'h0000, 16'h1000, 32'hFFFF_FFFF, 1'b0, '0},
        '{ora_pkg::OP_LOAD,   16'h1000, 16'h2000, 32'h0001_0000, 1'b0, '0},
        '{ora_pkg::OP_LOAD,   16'h2000, 16'h2000, 32'hFFFF_FFFF, 1'b0, '0},
        '{ora_pkg::OP_LOAD,   16'h3000, 16'h2800, 32'h0000_0005, 1'b0, '0},
        '{ora_pkg::OP_LOAD,   16'h2000, 16'h4000, 32'hFFFF_FFFF, 1'b0, '0},
        '{ora_pkg::OP_LOAD,   16'h4000, 16'hFFFF, 32'h1234_5678, 1'b0, '0},
        '{OP_UNUSED,          16'hA5A5, 16'h5A5A, 32'hDEAD_BEEF, 1'b0, '0},
        '{ora_pkg::OP_TARGET, 16'h0000, 16'h0800, 32'hFFFF_FFFF,
          1'b1, '{40'h0, 1'b0, 1'b0}},
        '{ora_pkg::OP_TARGET, 16'h1000, 16'h1800, 32'h0,   1'b0, '0},
        '{ora_pkg::OP_TARGET, 16'h1800, 16'h3000, 32'h0,   1'b0, '0},
        '{ora_pkg::OP_LOAD,   16'hFFFF, 16'hFFFF, 32'h0,   1'b0, '0},
        '{ora_pkg::OP_TARGET, 16'h5000, 16'h4000, 32'h0,   1'b0, '0},
        '{ora_pkg::OP_TARGET, 16'h3000, 16'hFFFF, 32'h0,   1'b0, '0},
        '{ora_pkg::OP_TARGET, 16'hFFFF, 16'hFFFF, 32'h0,   1'b1, '{40'h0, 1'b1, 1'b0}},
        '{ora_pkg::OP_CLEAR,  16'h0000, 16'h0000, 32'h0,   1'b0, '0},
        '{ora_pkg::OP_LOAD,   16'h0000, 16'h0000, 32'h0,   1'b0, '0},
        '{ora_pkg::OP_TARGET, 16'h0000, 16'hFFFF, 32'h0,   1'b1, '{40'h0, 1'b0, 1'b0}},
        '{ora_pkg::OP_TARGET, 16'h0000, 16'hFFFF, 32'h0,   1'b1, '{40'h0, 1'b1, 1'b0}}
    };

    initial
    begin
        int pass_no;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = ora_pkg::OP_CLEAR;
        bin_lower = '0;
        bin_upper = '0;
        bin_amount = '0;
        out_ready = 1'b0;
        errors = 0;
        items_sent = 0;
        targets_checked = 0;
        full_tables = 0;
        idle_mode = 0;
        hold_req = 1'b0;
        hold_cnt = 0;
        cycles = 0;
        tbl_count = 0;
        walk_ptr = 1;
        targets_seen = 0;
        pass_no = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table
        foreach (directed[i])
            send_item(directed[i].op, directed[i].lo, directed[i].up,
                      directed[i].amt, directed[i].typed, directed[i].res);

        // Random passes, rotating through the idling phases
        while (items_sent < 520) begin
            idle_mode = (pass_no / 3) % 4;
            // hold the receiver off while items keep coming
            if (pass_no == 8) hold_req = 1'b1;
            if (pass_no == 5) begin
                // overfill the table, then walk a long stretch of it
                run_pass(SRC_DEPTH + 4, 6);
                full_tables++;
            end
            else if ($urandom_range(5) == 0) begin
                repeat ($urandom_range(1, 6))
                    send_item(2'($urandom), 16'($urandom), 16'($urandom), $urandom);
            end
            else begin
                run_pass($urandom_range(2, 12), $urandom_range(2, 10));
            end
            pass_no++;
        end
        in_valid = 1'b0;

        // Drain and let the block settle
        while (expected_targets.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);

        $display("covered %0d items over %0d passes, %0d targets checked",
                 items_sent, pass_no, targets_checked);
        $display("idle phases 0-3 visited, %0d full-table pass(es), long receiver hold",
                 full_tables);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
